// ===== sv/edw_pkg.sv =====
package edw_pkg;

    // Command codes carried in the cmd field of an input transaction.
    localparam logic CMD_CHECK  = 1'b0;
    localparam logic CMD_RECORD = 1'b1;

    localparam int unsigned KEY_FIELD_BITS = 32;

    typedef struct packed {
        logic [KEY_FIELD_BITS-1:0] src_id;
        logic [KEY_FIELD_BITS-1:0] boot_id;
        logic [KEY_FIELD_BITS-1:0] evt_num;
    } key_t;

    typedef struct packed {
        logic valid;
        logic has_decision;
    } entry_flags_t;

    // Per-cycle control broadcast to every cell of the window.
    typedef struct packed {
        logic shift;   // insert a new key at the head, all entries move one cell down
        logic record;  // store the command's decision word in the matching entry
    } cell_ctrl_t;

endpackage

// ===== sv/edw_if.sv =====
interface edw_in_if #(
    parameter int unsigned DECISION_BITS = 64
);
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic [31:0]              src_id;
    logic [31:0]              boot_id;
    logic [31:0]              evt_num;
    logic [DECISION_BITS-1:0] decision_word;

    modport source (
        output valid, cmd, src_id, boot_id, evt_num, decision_word,
        input  ready
    );
    modport sink (
        input  valid, cmd, src_id, boot_id, evt_num, decision_word,
        output ready
    );
endinterface

interface edw_out_if #(
    parameter int unsigned DECISION_BITS = 64
);
    logic                     valid;
    logic                     ready;
    logic                     key_found;
    logic                     replay_valid;
    logic [DECISION_BITS-1:0] replay_decision;

    modport source (
        output valid, key_found, replay_valid, replay_decision,
        input  ready
    );
    modport sink (
        input  valid, key_found, replay_valid, replay_decision,
        output ready
    );
endinterface

// ===== sv/event_dedup_window_top.sv =====
// Channel   | Modport | Payload                                        | Role
// ----------+---------+------------------------------------------------+---------------------
// evt_in    | sink    | cmd, src_id, boot_id, evt_num, decision_word   | check or record cmd
// res_out   | source  | key_found, replay_valid, replay_decision       | one result per cmd
//
// A command is compared against every cell in the cycle it is presented and the window
// is updated at the accepting edge; its result is registered and shown in the next cycle.
// With the receiver ready a new transaction is accepted in every cycle; the compare
// across the cells and the OR of the matching decision set the path length.
// Reset clears the valid and decision flags of every cell and the output valid flag.
// evt_in stalls while a result waits in the output register and res_out is not ready.
module event_dedup_window_top #(
    parameter int unsigned WINDOW_DEPTH  = 8,
    parameter int unsigned DECISION_BITS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    edw_in_if.sink     evt_in,
    edw_out_if.source  res_out
);
    import edw_pkg::*;

    // The window is a chain of cells ordered from newest (cell 0) to oldest.
    // A check that misses shifts every entry one cell down and writes the new
    // key into cell 0; the oldest entry drops off the end. This is the same
    // round-robin replacement as an insert pointer, since the slot it would
    // overwrite is always the oldest one. A record updates its entry in place.

    key_t                     cmd_key;
    cell_ctrl_t               ctrl;
    logic                     in_fire;
    logic                     out_fire;

    key_t                     cell_key      [WINDOW_DEPTH];
    entry_flags_t             cell_flags    [WINDOW_DEPTH];
    logic [DECISION_BITS-1:0] cell_decision [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0]  match_vec;
    logic [WINDOW_DEPTH-1:0]  valid_vec;

    key_t                     chain_key      [WINDOW_DEPTH];
    entry_flags_t             chain_flags    [WINDOW_DEPTH];
    logic [DECISION_BITS-1:0] chain_decision [WINDOW_DEPTH];

    logic                     hit;
    logic                     hit_has_decision;
    logic [DECISION_BITS-1:0] hit_decision;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     key_found_reg;
    logic                     replay_valid_reg;
    logic [DECISION_BITS-1:0] replay_decision_reg;

    assign cmd_key.src_id  = evt_in.src_id;
    assign cmd_key.boot_id = evt_in.boot_id;
    assign cmd_key.evt_num = evt_in.evt_num;

    assign out_fire     = res_out.valid && res_out.ready;
    assign evt_in.ready = !out_valid_reg || res_out.ready;
    assign in_fire      = evt_in.valid && evt_in.ready;

    assign ctrl.shift  = in_fire && (evt_in.cmd == CMD_CHECK) && !hit;
    assign ctrl.record = in_fire && (evt_in.cmd == CMD_RECORD);

    // The head cell is fed with a fresh entry built from the incoming key.
    always_comb
    begin
        chain_key[0]                  = cmd_key;
        chain_flags[0].valid          = 1'b1;
        chain_flags[0].has_decision   = 1'b0;
        chain_decision[0]             = '0;
        for (int i = 1; i < WINDOW_DEPTH; i++)
        begin
            chain_key[i]      = cell_key[i-1];
            chain_flags[i]    = cell_flags[i-1];
            chain_decision[i] = cell_decision[i-1];
        end
    end

    for (genvar g = 0; g < WINDOW_DEPTH; g++)
    begin : g_cell
        edw_cell #(
            .DECISION_BITS (DECISION_BITS)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl),
            .cmd_key       (cmd_key),
            .cmd_word      (evt_in.decision_word),
            .prev_key      (chain_key[g]),
            .prev_flags    (chain_flags[g]),
            .prev_decision (chain_decision[g]),
            .key           (cell_key[g]),
            .flags         (cell_flags[g]),
            .decision      (cell_decision[g]),
            .match         (match_vec[g])
        );
        assign valid_vec[g] = cell_flags[g].valid;
    end

    // At most one cell can match, because a check inserts only on a miss, so the
    // matching decision is gathered with a plain AND-OR over the cells.
    always_comb
    begin
        hit              = 1'b0;
        hit_has_decision = 1'b0;
        hit_decision     = '0;
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            if (match_vec[i])
            begin
                hit = 1'b1;
                if (cell_flags[i].has_decision)
                begin
                    hit_has_decision = 1'b1;
                    hit_decision     = hit_decision | cell_decision[i];
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Replay data is reported only for a check that hits an entry with a decision.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            key_found_reg <= hit;
            if ((evt_in.cmd == CMD_CHECK) && hit_has_decision)
            begin
                replay_valid_reg    <= 1'b1;
                replay_decision_reg <= hit_decision;
            end
            else
            begin
                replay_valid_reg    <= 1'b0;
                replay_decision_reg <= '0;
            end
        end
    end

    assign res_out.valid           = out_valid_reg;
    assign res_out.key_found       = key_found_reg;
    assign res_out.replay_valid    = replay_valid_reg;
    assign res_out.replay_decision = replay_decision_reg;

`ifndef SYNTHESIS
    // No key may ever be held by two valid cells.
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("more than one window entry matches the key");

    // A check that misses leaves its key valid in the head cell.
    a_insert_head: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (evt_in.cmd == CMD_CHECK) && !hit) |=>
            (cell_flags[0].valid && (cell_key[0] == $past(cmd_key))))
        else $error("missed key not inserted at the head of the window");

    // A record never changes which entries are valid.
    a_record_keeps_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (evt_in.cmd == CMD_RECORD)) |=> $stable(valid_vec))
        else $error("record command changed the valid entries");

    // A new result appears only after an accepted command.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_fire))
        else $error("result presented without an accepted command");
`endif

endmodule

// ===== sv/edw_cell.sv =====
module edw_cell #(
    parameter int unsigned DECISION_BITS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  edw_pkg::cell_ctrl_t        ctrl,
    input  edw_pkg::key_t              cmd_key,
    input  logic [DECISION_BITS-1:0]   cmd_word,
    input  edw_pkg::key_t              prev_key,
    input  edw_pkg::entry_flags_t      prev_flags,
    input  logic [DECISION_BITS-1:0]   prev_decision,
    output edw_pkg::key_t              key,
    output edw_pkg::entry_flags_t      flags,
    output logic [DECISION_BITS-1:0]   decision,
    output logic                       match
);
    import edw_pkg::*;

    key_t                     key_reg;
    entry_flags_t             flags_reg;
    logic [DECISION_BITS-1:0] decision_reg;

    // One entry of the window; it matches only while it holds a valid key.
    assign match = flags_reg.valid && (key_reg == cmd_key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            flags_reg <= prev_flags;
        end
        else if (ctrl.record && match)
        begin
            flags_reg.has_decision <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            key_reg      <= prev_key;
            decision_reg <= prev_decision;
        end
        else if (ctrl.record && match)
        begin
            decision_reg <= cmd_word;
        end
    end

    assign key      = key_reg;
    assign flags    = flags_reg;
    assign decision = decision_reg;

endmodule
